// ===== rtl/cafu_pkg.sv =====
`timescale 1ns / 1ps

package cafu_pkg;

    localparam int unsigned OP_W = 5;

    localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
    localparam logic [OP_W-1:0] OP_SBC   = 5'd3;
    localparam logic [OP_W-1:0] OP_AND   = 5'd4;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd5;
    localparam logic [OP_W-1:0] OP_OR    = 5'd6;
    localparam logic [OP_W-1:0] OP_CP    = 5'd7;
    localparam logic [OP_W-1:0] OP_INC   = 5'd8;
    localparam logic [OP_W-1:0] OP_DEC   = 5'd9;
    localparam logic [OP_W-1:0] OP_RLCA  = 5'd10;
    localparam logic [OP_W-1:0] OP_RRCA  = 5'd11;
    localparam logic [OP_W-1:0] OP_RLA   = 5'd12;
    localparam logic [OP_W-1:0] OP_RRA   = 5'd13;
    localparam logic [OP_W-1:0] OP_DAA   = 5'd14;
    localparam logic [OP_W-1:0] OP_CPL   = 5'd15;
    localparam logic [OP_W-1:0] OP_SCF   = 5'd16;
    localparam logic [OP_W-1:0] OP_CCF   = 5'd17;
    localparam logic [OP_W-1:0] OP_RLC   = 5'd18;
    localparam logic [OP_W-1:0] OP_RRC   = 5'd19;
    localparam logic [OP_W-1:0] OP_RL    = 5'd20;
    localparam logic [OP_W-1:0] OP_RR    = 5'd21;
    localparam logic [OP_W-1:0] OP_SLA   = 5'd22;
    localparam logic [OP_W-1:0] OP_SRA   = 5'd23;
    localparam logic [OP_W-1:0] OP_SWAP  = 5'd24;
    localparam logic [OP_W-1:0] OP_SRL   = 5'd25;
    localparam logic [OP_W-1:0] OP_BIT   = 5'd26;
    localparam logic [OP_W-1:0] OP_RES   = 5'd27;
    localparam logic [OP_W-1:0] OP_SET   = 5'd28;
    localparam logic [OP_W-1:0] OP_ADD16 = 5'd29;
    localparam logic [OP_W-1:0] OP_ADDSP = 5'd30;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [7:0]      acc_value;
        logic [7:0]      operand_byte;
        logic [2:0]      bit_index;
        logic [15:0]     word_base;
        logic [15:0]     word_addend;
        logic [3:0]      flags_in;
    } cafu_in_t;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_word;
        logic [3:0]  flags_out;
        logic        write_back;
    } cafu_out_t;

endpackage

// ===== rtl/cafu_channels.sv =====
`timescale 1ns / 1ps

interface cafu_in_if;
    logic               valid;
    logic               ready;
    cafu_pkg::cafu_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cafu_out_if;
    logic                valid;
    logic                ready;
    cafu_pkg::cafu_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cpu_alu_flags_unit.sv =====
`timescale 1ns / 1ps
// a result passes through the operand register and then the result register before it is offered
// throughput: one transaction per cycle while the output accepts results, set by the operand and result registers
// the operand register can still take a transaction while a finished result waits in the result register
// reset: rst_n asynchronous, active low, clears both valid flags only
// no state carries from one transaction to the next

module cpu_alu_flags_unit
(
    input  logic              clk,
    input  logic              rst_n,
    cafu_in_if.sink           in_chan,
    cafu_out_if.source        out_chan
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    cafu_pkg::cafu_in_t  s1_data_reg;
    logic                s2_valid_reg;
    logic                s2_valid_next;
    cafu_pkg::cafu_out_t s2_data_reg;
    cafu_pkg::cafu_out_t s2_data_next;

    logic s1_ready;
    logic s2_ready;
    logic s1_load;
    logic s2_load;

    assign s2_ready = !s2_valid_reg || out_chan.ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = in_chan.valid && s1_ready;
    assign s2_load  = s1_valid_reg && s2_ready;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s2_ready);
    assign s2_valid_next = s2_load || (s2_valid_reg && !out_chan.ready);

    cafu_core u_core
    (
        .operands (s1_data_reg),
        .results  (s2_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= in_chan.data;
        end
        if (s2_load)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign in_chan.ready  = s1_ready;
    assign out_chan.valid = s2_valid_reg;
    assign out_chan.data  = s2_data_reg;

endmodule

// ===== rtl/cafu_core.sv =====
`timescale 1ns / 1ps

module cafu_core
(
    input  cafu_pkg::cafu_in_t  operands,
    output cafu_pkg::cafu_out_t results
);

    logic [4:0]  op;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [2:0]  bi;
    logic [15:0] wb;
    logic [15:0] wa;
    logic [3:0]  f;
    logic        c;

    logic        add_cin;
    logic        sub_cin;
    logic [8:0]  add9;
    logic [4:0]  add_lo;
    logic [8:0]  sub9;
    logic [4:0]  sub_lo;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_adj;
    logic [7:0]  daa_res;
    logic [7:0]  bit_mask;
    logic [16:0] add16;
    logic [12:0] add16_lo;
    logic [15:0] sp_ext;
    logic [4:0]  sp_lo4;
    logic [8:0]  sp_lo8;

    logic [7:0]  rb;
    logic [15:0] rw;
    logic [3:0]  nf;
    logic        we;

    assign op = operands.operation;
    assign a  = operands.acc_value;
    assign b  = operands.operand_byte;
    assign bi = operands.bit_index;
    assign wb = operands.word_base;
    assign wa = operands.word_addend;
    assign f  = operands.flags_in;
    assign c  = f[cafu_pkg::FLAG_C];

    assign add_cin = (op == cafu_pkg::OP_ADC) && c;
    assign sub_cin = (op == cafu_pkg::OP_SBC) && c;
    assign add9    = {1'b0, a} + {1'b0, b} + {8'b0, add_cin};
    assign add_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, add_cin};
    assign sub9    = {1'b0, a} - {1'b0, b} - {8'b0, sub_cin};
    assign sub_lo  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, sub_cin};
    assign inc8    = a + 8'd1;
    assign dec8    = a - 8'd1;

    // decimal adjust after add or subtract
    assign daa_lo  = f[cafu_pkg::FLAG_N] ? f[cafu_pkg::FLAG_H]
                   : (f[cafu_pkg::FLAG_H] || (a[3:0] > cafu_pkg::DAA_LO_LIMIT));
    assign daa_hi  = f[cafu_pkg::FLAG_N] ? c : (c || (a > cafu_pkg::DAA_HI_LIMIT));
    assign daa_adj = (daa_hi ? cafu_pkg::DAA_HI_ADJ : 8'h00)
                   | (daa_lo ? cafu_pkg::DAA_LO_ADJ : 8'h00);
    assign daa_res = f[cafu_pkg::FLAG_N] ? (a - daa_adj) : (a + daa_adj);

    assign bit_mask = 8'b1 << bi;

    assign add16    = {1'b0, wb} + {1'b0, wa};
    assign add16_lo = {1'b0, wb[11:0]} + {1'b0, wa[11:0]};
    assign sp_ext   = {{8{b[7]}}, b};
    assign sp_lo4   = {1'b0, wb[3:0]} + {1'b0, b[3:0]};
    assign sp_lo8   = {1'b0, wb[7:0]} + {1'b0, b};

    always_comb
    begin
        rb = 8'h00;
        rw = 16'h0000;
        nf = f;
        we = 1'b1;
        case (op)
            cafu_pkg::OP_ADD, cafu_pkg::OP_ADC:
            begin
                rb = add9[7:0];
                nf = {rb == 8'h00, 1'b0, add_lo[4], add9[8]};
            end
            cafu_pkg::OP_SUB, cafu_pkg::OP_SBC, cafu_pkg::OP_CP:
            begin
                rb = sub9[7:0];
                nf = {rb == 8'h00, 1'b1, sub_lo[4], sub9[8]};
                if (op == cafu_pkg::OP_CP)
                begin
                    rb = a;
                    we = 1'b0;
                end
            end
            cafu_pkg::OP_AND:
            begin
                rb = a & b;
                nf = {rb == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            cafu_pkg::OP_XOR:
            begin
                rb = a ^ b;
                nf = {rb == 8'h00, 3'b000};
            end
            cafu_pkg::OP_OR:
            begin
                rb = a | b;
                nf = {rb == 8'h00, 3'b000};
            end
            cafu_pkg::OP_INC:
            begin
                rb = inc8;
                nf = {rb == 8'h00, 1'b0, a[3:0] == 4'hF, c};
            end
            cafu_pkg::OP_DEC:
            begin
                rb = dec8;
                nf = {rb == 8'h00, 1'b1, a[3:0] == 4'h0, c};
            end
            cafu_pkg::OP_RLCA, cafu_pkg::OP_RLC:
            begin
                rb = {a[6:0], a[7]};
                nf = {(op == cafu_pkg::OP_RLC) && (rb == 8'h00), 2'b00, a[7]};
            end
            cafu_pkg::OP_RRCA, cafu_pkg::OP_RRC:
            begin
                rb = {a[0], a[7:1]};
                nf = {(op == cafu_pkg::OP_RRC) && (rb == 8'h00), 2'b00, a[0]};
            end
            cafu_pkg::OP_RLA, cafu_pkg::OP_RL:
            begin
                rb = {a[6:0], c};
                nf = {(op == cafu_pkg::OP_RL) && (rb == 8'h00), 2'b00, a[7]};
            end
            cafu_pkg::OP_RRA, cafu_pkg::OP_RR:
            begin
                rb = {c, a[7:1]};
                nf = {(op == cafu_pkg::OP_RR) && (rb == 8'h00), 2'b00, a[0]};
            end
            cafu_pkg::OP_DAA:
            begin
                rb = daa_res;
                nf = {rb == 8'h00, f[cafu_pkg::FLAG_N], 1'b0,
                      f[cafu_pkg::FLAG_N] ? c : daa_hi};
            end
            cafu_pkg::OP_CPL:
            begin
                rb = ~a;
                nf = {f[cafu_pkg::FLAG_Z], 1'b1, 1'b1, c};
            end
            cafu_pkg::OP_SCF:
            begin
                rb = a;
                nf = {f[cafu_pkg::FLAG_Z], 2'b00, 1'b1};
            end
            cafu_pkg::OP_CCF:
            begin
                rb = a;
                nf = {f[cafu_pkg::FLAG_Z], 2'b00, ~c};
            end
            cafu_pkg::OP_SLA:
            begin
                rb = {a[6:0], 1'b0};
                nf = {rb == 8'h00, 2'b00, a[7]};
            end
            cafu_pkg::OP_SRA:
            begin
                rb = {a[7], a[7:1]};
                nf = {rb == 8'h00, 2'b00, a[0]};
            end
            cafu_pkg::OP_SWAP:
            begin
                rb = {a[3:0], a[7:4]};
                nf = {rb == 8'h00, 3'b000};
            end
            cafu_pkg::OP_SRL:
            begin
                rb = {1'b0, a[7:1]};
                nf = {rb == 8'h00, 2'b00, a[0]};
            end
            cafu_pkg::OP_BIT:
            begin
                rb = a;
                we = 1'b0;
                nf = {~a[bi], 1'b0, 1'b1, c};
            end
            cafu_pkg::OP_RES:
            begin
                rb = a & ~bit_mask;
            end
            cafu_pkg::OP_SET:
            begin
                rb = a | bit_mask;
            end
            cafu_pkg::OP_ADD16:
            begin
                rw = add16[15:0];
                nf = {f[cafu_pkg::FLAG_Z], 1'b0, add16_lo[12], add16[16]};
            end
            cafu_pkg::OP_ADDSP:
            begin
                rw = wb + sp_ext;
                nf = {2'b00, sp_lo4[4], sp_lo8[8]};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign results.result_byte = rb;
    assign results.result_word = rw;
    assign results.flags_out   = nf;
    assign results.write_back  = we;

endmodule
